// ----- rtl/core/dq_pkg.sv -----
// dq_pkg: shared types, operation and status codes for the double-ended queue
// used by dq_ctrl, dq_datapath and double_ended_queue_top; no dependencies
`default_nettype none

package dq_pkg;

    localparam int DQ_DEPTH_DEF = 1024;
    localparam int WORD_W       = 32;

    localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [2:0] FUNC_NOP        = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic signed [WORD_W-1:0] WORD_NONE = -32'sd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_DONE
    } t_dq_state;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic fill;
        logic out_load;
    } t_dq_cmd;

    typedef struct packed {
        logic need_read;
        logic out_free;
    } t_dq_sts;

endpackage

`default_nettype wire

// ----- rtl/core/dq_ctrl.sv -----
// dq_ctrl: sequencing state machine for the double-ended queue
// depends on dq_pkg; drives dq_datapath through t_dq_cmd
`default_nettype none

module dq_ctrl
    import dq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dq_sts i_sts,
    output t_dq_cmd      o_cmd
);

    t_dq_state r_state;
    t_dq_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.need_read ? S_FILL : S_DONE;
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/dq_datapath.sv -----
// dq_datapath: word store, pointers, cached end words and result register
// depends on dq_pkg; commanded by dq_ctrl
`default_nettype none

module dq_datapath
    import dq_pkg::*;
#(
    parameter int DEPTH = DQ_DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dq_cmd                  i_cmd,
    output t_dq_sts                       o_sts,
    input  wire logic [2:0]               i_func,
    input  wire logic signed [WORD_W-1:0] i_push_value,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed [WORD_W-1:0]      o_popped_value,
    output logic [1:0]                    o_status,
    output logic [CNT_W-1:0]              o_entry_count,
    output logic                          o_is_empty,
    output logic signed [WORD_W-1:0]      o_front_value,
    output logic signed [WORD_W-1:0]      o_back_value
);

    localparam int PTR_W = $clog2(DEPTH);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
    endfunction

    logic signed [WORD_W-1:0] r_mem [DEPTH];
    logic signed [WORD_W-1:0] r_rd_data;

    logic [2:0]               r_func;
    logic signed [WORD_W-1:0] r_value;
    logic [PTR_W-1:0]         r_head;
    logic [PTR_W-1:0]         r_tail;
    logic [CNT_W-1:0]         r_count;
    logic signed [WORD_W-1:0] r_front;
    logic signed [WORD_W-1:0] r_back;
    logic signed [WORD_W-1:0] r_popped;
    logic [1:0]               r_stat;
    logic                     r_fill_front;

    logic                     r_o_valid;
    logic signed [WORD_W-1:0] r_o_popped;
    logic [1:0]               r_o_status;
    logic [CNT_W-1:0]         r_o_count;
    logic                     r_o_empty;
    logic signed [WORD_W-1:0] r_o_front;
    logic signed [WORD_W-1:0] r_o_back;

    logic [PTR_W-1:0]         n_head;
    logic [PTR_W-1:0]         n_tail;
    logic [CNT_W-1:0]         n_count;
    logic signed [WORD_W-1:0] n_front;
    logic signed [WORD_W-1:0] n_back;
    logic signed [WORD_W-1:0] n_popped;
    logic [1:0]               n_stat;
    logic                     n_fill_front;
    logic                     need_read;
    logic                     wr_en;
    logic [PTR_W-1:0]         wr_addr;
    logic [PTR_W-1:0]         rd_addr;
    logic                     is_full;
    logic                     is_empty;

    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_front      = r_front;
        n_back       = r_back;
        n_popped     = WORD_NONE;
        n_stat       = STATUS_OK;
        n_fill_front = 1'b1;
        need_read    = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = r_tail;
        rd_addr      = r_head;
        case (r_func)
            FUNC_PUSH_FRONT: begin
                if (is_full) begin
                    n_stat = STATUS_FULL;
                end else begin
                    n_head  = ptr_dec(r_head);
                    wr_en   = i_cmd.exec;
                    wr_addr = ptr_dec(r_head);
                    n_count = r_count + CNT_W'(1);
                    n_front = r_value;
                    if (is_empty) begin
                        n_back = r_value;
                    end
                end
            end
            FUNC_PUSH_BACK: begin
                if (is_full) begin
                    n_stat = STATUS_FULL;
                end else begin
                    n_tail  = ptr_inc(r_tail);
                    wr_en   = i_cmd.exec;
                    wr_addr = r_tail;
                    n_count = r_count + CNT_W'(1);
                    n_back  = r_value;
                    if (is_empty) begin
                        n_front = r_value;
                    end
                end
            end
            FUNC_POP_FRONT: begin
                if (is_empty) begin
                    n_stat = STATUS_EMPTY;
                end else begin
                    n_popped  = r_front;
                    n_head    = ptr_inc(r_head);
                    n_count   = r_count - CNT_W'(1);
                    rd_addr   = ptr_inc(r_head);
                    need_read = (r_count != CNT_W'(1));
                end
            end
            FUNC_POP_BACK: begin
                if (is_empty) begin
                    n_stat = STATUS_EMPTY;
                end else begin
                    n_popped     = r_back;
                    n_tail       = ptr_dec(r_tail);
                    n_count      = r_count - CNT_W'(1);
                    rd_addr      = ptr_dec(ptr_dec(r_tail));
                    need_read    = (r_count != CNT_W'(1));
                    n_fill_front = 1'b0;
                end
            end
            default: begin
                n_stat = STATUS_OK;
            end
        endcase
    end

    assign o_sts.need_read = need_read;
    assign o_sts.out_free  = !r_o_valid || i_out_ready;

    // word store, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func  <= i_func;
            r_value <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_front      <= n_front;
            r_back       <= n_back;
            r_popped     <= n_popped;
            r_stat       <= n_stat;
            r_fill_front <= n_fill_front;
        end else if (i_cmd.fill) begin
            if (r_fill_front) begin
                r_front <= r_rd_data;
            end else begin
                r_back <= r_rd_data;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_popped <= r_popped;
            r_o_status <= r_stat;
            r_o_count  <= r_count;
            r_o_empty  <= is_empty;
            r_o_front  <= is_empty ? WORD_NONE : r_front;
            r_o_back   <= is_empty ? WORD_NONE : r_back;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_popped_value = r_o_popped;
    assign o_status       = r_o_status;
    assign o_entry_count  = r_o_count;
    assign o_is_empty     = r_o_empty;
    assign o_front_value  = r_o_front;
    assign o_back_value   = r_o_back;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_head) < DEPTH) && (32'(r_tail) < DEPTH))
        else $error("pointer outside store");

    a_fill_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill |-> $past(i_cmd.exec && need_read))
        else $error("cache fill without a store read");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_o_valid || i_out_ready))
        else $error("result register overwritten");

endmodule

`default_nettype wire

// ----- rtl/core/double_ended_queue_top.sv -----
// Double-ended queue of signed 32-bit words in a circular store of DEPTH entries.
// Each input transaction pushes to the front or back, pops from the front or back, or
// does nothing, and yields exactly one result transaction with the popped word (-1 when
// none), a status code, the count, an empty flag and the front and back words after the
// step (-1 while empty). One item is handled at a time: an accepted item passes through
// the execute state, a fill state for a pop that leaves the queue non-empty (the new end
// word comes through the store's single registered read port) and the done state, which
// waits for the output register to be free. The result sits in that register, so the
// next item is accepted while it waits. The word store needs no clearing after reset; only
// state, pointers, count and valid flag are reset. Depends on dq_pkg, dq_ctrl, dq_datapath.
`default_nettype none

module double_ended_queue_top
    import dq_pkg::*;
#(
    parameter int DEPTH = DQ_DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [2:0]               i_func,
    input  wire logic signed [WORD_W-1:0] i_push_value,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed [WORD_W-1:0]      o_popped_value,
    output logic [1:0]                    o_status,
    output logic [CNT_W-1:0]              o_entry_count,
    output logic                          o_is_empty,
    output logic signed [WORD_W-1:0]      o_front_value,
    output logic signed [WORD_W-1:0]      o_back_value
);

    t_dq_cmd cmd;
    t_dq_sts sts;

    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dq_datapath #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_func         (i_func),
        .i_push_value   (i_push_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count),
        .o_is_empty     (o_is_empty),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value)
    );

endmodule

`default_nettype wire
